/* design/lif_spiking_fc_layer_unit_assert.svh */
// ----------------------------------------------------------------------------
// LIF layer assertion macros
// Shared concurrent assertion forms for the checker of the LIF layer.
// ----------------------------------------------------------------------------
`ifndef LIF_SPIKING_FC_LAYER_UNIT_ASSERT_SVH
`define LIF_SPIKING_FC_LAYER_UNIT_ASSERT_SVH
`define LSFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`define LSFC_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);
`endif

/* design/lsfc_pkg.sv */
// ----------------------------------------------------------------------------
// LIF layer package
// Command and register codes, configuration struct and shared arithmetic.
// ----------------------------------------------------------------------------
package lsfc_pkg;

  localparam int NUM_INPUTS_DEF  = 1024;
  localparam int NUM_NEURONS_DEF = 16;
  localparam int CMDQ_DEPTH      = 4;
  localparam int OP_W            = 3;

  typedef enum logic [2:0] {
    CMD_LOAD_W = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_SPIKE  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_DECAY       = 3'd1,
    CFG_SHIFT       = 3'd2,
    CFG_ACTIVE      = 3'd3,
    CFG_INPUT_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_W = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_SPIKE  = 3'd2,
    OP_STEP   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef struct packed {
    logic [30:0] threshold;
    logic [6:0]  decay_factor;
    logic [4:0]  decay_shift;
    logic [4:0]  active_neurons;
    logic [10:0] input_count;
  } cfg_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic signed [31:0] sat_to32(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = 40'shFF80000000;
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end
    if (x < lo) begin
      return 32'sh80000000;
    end
    return $signed(x[31:0]);
  endfunction

endpackage

/* design/lsfc_cmdq.sv */
// ----------------------------------------------------------------------------
// LIF layer request queue
// Small register FIFO between the request classifier and the execution unit.
// ----------------------------------------------------------------------------
module lsfc_cmdq #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* design/lsfc_front.sv */
// ----------------------------------------------------------------------------
// LIF layer request classifier
// Decodes incoming requests, drops unused and out-of-range ones and forms memory addresses.
// ----------------------------------------------------------------------------
module lsfc_front #(
  parameter int NUM_INPUTS  = lsfc_pkg::NUM_INPUTS_DEF,
  parameter int NUM_NEURONS = lsfc_pkg::NUM_NEURONS_DEF
) (
  input  logic                                            in_push,
  input  logic [2:0]                                      in_cmd,
  input  logic [9:0]                                      in_pre_index,
  input  logic [3:0]                                      in_neuron,
  input  logic signed [7:0]                               in_value,
  input  lsfc_pkg::cfg_t                                  cfg,
  input  logic                                            q_full,
  output logic                                            q_push,
  output lsfc_pkg::op_t                                   q_op,
  output logic [$clog2(NUM_INPUTS*NUM_NEURONS)-1:0]       q_addr,
  output logic [lsfc_pkg::idx_w(NUM_NEURONS)-1:0]         q_nidx,
  output logic signed [7:0]                               q_value
);
  import lsfc_pkg::*;

  localparam int WA_W  = $clog2(NUM_INPUTS * NUM_NEURONS);
  localparam int IDX_W = idx_w(NUM_NEURONS);

  logic keep;
  logic pre_ok;
  logic nrn_ok;

  assign pre_ok  = (32'(in_pre_index) < NUM_INPUTS);
  assign nrn_ok  = (32'(in_neuron) < NUM_NEURONS);
  assign q_nidx  = IDX_W'(in_neuron);
  assign q_value = in_value;

  always_comb begin
    keep   = 1'b0;
    q_op   = OP_CLEAR;
    q_addr = WA_W'(32'(in_pre_index) * NUM_NEURONS);
    case (in_cmd)
      CMD_LOAD_W: begin
        q_op   = OP_LOAD_W;
        keep   = pre_ok && nrn_ok;
        q_addr = WA_W'(32'(in_pre_index) * NUM_NEURONS + 32'(in_neuron));
      end
      CMD_LOAD_B: begin
        q_op = OP_LOAD_B;
        keep = nrn_ok;
      end
      CMD_SPIKE: begin
        q_op = OP_SPIKE;
        keep = pre_ok && ({1'b0, in_pre_index} < cfg.input_count);
      end
      CMD_STEP: begin
        q_op = OP_STEP;
        keep = 1'b1;
      end
      CMD_CLEAR: begin
        q_op = OP_CLEAR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_push && !q_full && keep;

endmodule

/* design/lsfc_back.sv */
// ----------------------------------------------------------------------------
// LIF layer execution unit
// Holds weights, biases, accumulators and membranes and runs one neuron a cycle.
// ----------------------------------------------------------------------------
module lsfc_back #(
  parameter int NUM_INPUTS  = lsfc_pkg::NUM_INPUTS_DEF,
  parameter int NUM_NEURONS = lsfc_pkg::NUM_NEURONS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  lsfc_pkg::cfg_t                                  cfg,
  input  logic                                            q_empty,
  output logic                                            q_pop,
  input  lsfc_pkg::op_t                                   q_op,
  input  logic [$clog2(NUM_INPUTS*NUM_NEURONS)-1:0]       q_addr,
  input  logic [lsfc_pkg::idx_w(NUM_NEURONS)-1:0]         q_nidx,
  input  logic signed [7:0]                               q_value,
  output logic                                            out_empty,
  input  logic                                            out_pop,
  output logic [15:0]                                     out_spike_mask
);
  import lsfc_pkg::*;

  localparam int WA_W  = $clog2(NUM_INPUTS * NUM_NEURONS);
  localparam int IDX_W = idx_w(NUM_NEURONS);
  localparam int CNT_W = $clog2(NUM_NEURONS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SPIKE = 5'b00010,
    S_STEP  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  logic signed [7:0]  weight_mem [NUM_INPUTS*NUM_NEURONS];
  logic signed [7:0]  bias_mem   [NUM_NEURONS];
  logic signed [31:0] acc_mem    [NUM_NEURONS];
  logic signed [31:0] mbr_mem    [NUM_NEURONS];

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         act;
  logic [IDX_W-1:0]         cur_idx;
  logic                     last;
  logic                     issue_spk;
  logic                     issue_stp;
  logic                     drained;
  logic [WA_W-1:0]          base_r;
  logic [NUM_NEURONS-1:0]   acc_vld_r;
  logic [NUM_NEURONS-1:0]   mbr_vld_r;
  logic [15:0]              mask_r;
  logic                     out_vld_r;
  logic [15:0]              out_mask_r;
  logic                     emit;

  logic                     rd_spk_r, rd_stp_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic signed [7:0]        w_q_r;
  logic signed [7:0]        bias_q_r;
  logic signed [31:0]       acc_q_r;
  logic signed [31:0]       mbr_q_r;
  logic                     acc_qv_r;
  logic                     mbr_qv_r;
  logic signed [31:0]       a1;
  logic signed [31:0]       m1;
  logic signed [7:0]        dec_s;
  logic signed [31:0]       acc_sum;

  logic                     p2_vld_r, p3_vld_r, p4_vld_r;
  logic [IDX_W-1:0]         p2_idx_r, p3_idx_r, p4_idx_r;
  logic signed [39:0]       prod_r;
  logic signed [33:0]       ab_r, ab3_r;
  logic signed [31:0]       lv_r;
  logic signed [31:0]       v_r;
  logic signed [32:0]       v_ext;
  logic signed [32:0]       thr_ext;
  logic                     fire;
  logic signed [31:0]       v_new;
  logic [7:0]               idx8;

  assign act = (32'(cfg.active_neurons) >= NUM_NEURONS) ? CNT_W'(NUM_NEURONS)
                                                        : CNT_W'(cfg.active_neurons);
  assign cur_idx   = cnt_r[IDX_W-1:0];
  assign last      = (cnt_r == act - 1'b1);
  assign issue_spk = (state_r == S_SPIKE);
  assign issue_stp = (state_r == S_STEP);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign drained   = !rd_stp_r && !p2_vld_r && !p3_vld_r && !p4_vld_r;
  assign emit      = (state_r == S_EMIT) && (!out_vld_r || out_pop);
  assign out_empty = !out_vld_r;
  assign out_spike_mask = out_mask_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (!q_empty) begin
          if (q_op == OP_SPIKE && act != '0) begin
            state_nxt = S_SPIKE;
          end else if (q_op == OP_STEP) begin
            state_nxt = (act != '0) ? S_STEP : S_DRAIN;
          end
        end
      end
      S_SPIKE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_IDLE;
        end
      end
      S_STEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign a1      = acc_qv_r ? acc_q_r : 32'sd0;
  assign m1      = mbr_qv_r ? mbr_q_r : 32'sd0;
  assign dec_s   = $signed({1'b0, cfg.decay_factor});
  assign acc_sum = sat_to32(40'(a1) + 40'(w_q_r));

  assign v_ext   = 33'(v_r);
  assign thr_ext = $signed({2'b00, cfg.threshold});
  assign fire    = (v_ext >= thr_ext);
  assign v_new   = fire ? 32'(v_ext - thr_ext) : v_r;
  assign idx8    = 8'(p4_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      acc_vld_r <= '0;
      mbr_vld_r <= '0;
      out_vld_r <= 1'b0;
      rd_spk_r  <= 1'b0;
      rd_stp_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_spk_r <= issue_spk;
      rd_stp_r <= issue_stp;
      p2_vld_r <= rd_stp_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      if (rd_spk_r) begin
        acc_vld_r[rd_idx_r] <= 1'b1;
      end
      if (p4_vld_r) begin
        mbr_vld_r[p4_idx_r] <= 1'b1;
      end
      if (state_r == S_DRAIN && drained) begin
        acc_vld_r <= '0;
      end
      if (q_pop && q_op == OP_CLEAR) begin
        acc_vld_r <= '0;
        mbr_vld_r <= '0;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op == OP_SPIKE) begin
      base_r <= q_addr;
    end
    if (q_pop && q_op == OP_STEP) begin
      mask_r <= '0;
    end else if (p4_vld_r && fire && idx8 < 8'd16) begin
      mask_r[idx8[3:0]] <= 1'b1;
    end
    if (emit) begin
      out_mask_r <= mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op == OP_LOAD_W) begin
      weight_mem[q_addr] <= q_value;
    end
    w_q_r <= weight_mem[base_r + WA_W'(cur_idx)];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op == OP_LOAD_B) begin
      bias_mem[q_nidx] <= q_value;
    end
    bias_q_r <= bias_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (rd_spk_r) begin
      acc_mem[rd_idx_r] <= acc_sum;
    end
    acc_q_r <= acc_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (p4_vld_r) begin
      mbr_mem[p4_idx_r] <= v_new;
    end
    mbr_q_r <= mbr_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cur_idx;
    acc_qv_r <= acc_vld_r[cur_idx];
    mbr_qv_r <= mbr_vld_r[cur_idx];
    p2_idx_r <= rd_idx_r;
    prod_r   <= dec_s * m1;
    ab_r     <= 34'(a1) + 34'(bias_q_r);
    p3_idx_r <= p2_idx_r;
    lv_r     <= sat_to32(prod_r >>> cfg.decay_shift);
    ab3_r    <= ab_r;
    p4_idx_r <= p3_idx_r;
    v_r      <= sat_to32(40'(lv_r) + 40'(ab3_r));
  end

endmodule

/* design/lif_spiking_fc_layer_unit.sv */
// ----------------------------------------------------------------------------
// LIF spiking fully connected layer
// Requests are taken into a four-entry queue at one per cycle while it is not
// full; the execution unit then works through them one at a time. Weight
// loads, bias loads and clears are done as they are popped, and dropped
// requests never enter the queue. For a spike, each active neuron needs one
// read of the weight memory and one read-modify-write of its accumulator.
// Closing a timestep visits each active neuron, lets the leak, sum and fire
// pipeline drain, and then posts the spike mask into the single-entry result
// register, waiting while the previous mask has not been popped. No clearing
// pass follows reset; weights and biases hold garbage until loaded.
// ----------------------------------------------------------------------------
module lif_spiking_fc_layer_unit #(
  parameter int NUM_INPUTS  = lsfc_pkg::NUM_INPUTS_DEF,
  parameter int NUM_NEURONS = lsfc_pkg::NUM_NEURONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_cmd,
  input  logic [9:0]        in_pre_index,
  input  logic [3:0]        in_neuron,
  input  logic signed [7:0] in_value,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [15:0]       out_spike_mask,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  import lsfc_pkg::*;

  localparam int WA_W  = $clog2(NUM_INPUTS * NUM_NEURONS);
  localparam int IDX_W = idx_w(NUM_NEURONS);
  localparam int Q_W   = OP_W + WA_W + IDX_W + 8;

  cfg_t              cfg_r;
  logic              f_push;
  op_t               f_op;
  logic [WA_W-1:0]   f_addr;
  logic [IDX_W-1:0]  f_nidx;
  logic signed [7:0] f_value;
  logic              cq_full;
  logic              cq_empty;
  logic              cq_pop;
  logic [Q_W-1:0]    cq_din;
  logic [Q_W-1:0]    cq_dout;
  logic [OP_W-1:0]   h_op;
  logic [WA_W-1:0]   h_addr;
  logic [IDX_W-1:0]  h_nidx;
  logic [7:0]        h_value;

  assign cfg_ready = 1'b1;
  assign in_full   = cq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= 31'd128;
      cfg_r.decay_factor   <= 7'd115;
      cfg_r.decay_shift    <= 5'd7;
      cfg_r.active_neurons <= 5'd16;
      cfg_r.input_count    <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD:   cfg_r.threshold      <= cfg_data;
        CFG_DECAY:       cfg_r.decay_factor   <= cfg_data[6:0];
        CFG_SHIFT:       cfg_r.decay_shift    <= cfg_data[4:0];
        CFG_ACTIVE:      cfg_r.active_neurons <= cfg_data[4:0];
        CFG_INPUT_COUNT: cfg_r.input_count    <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  lsfc_front #(
    .NUM_INPUTS  (NUM_INPUTS),
    .NUM_NEURONS (NUM_NEURONS)
  ) u_front (
    .in_push      (in_push),
    .in_cmd       (in_cmd),
    .in_pre_index (in_pre_index),
    .in_neuron    (in_neuron),
    .in_value     (in_value),
    .cfg          (cfg_r),
    .q_full       (cq_full),
    .q_push       (f_push),
    .q_op         (f_op),
    .q_addr       (f_addr),
    .q_nidx       (f_nidx),
    .q_value      (f_value)
  );

  assign cq_din = {f_op, f_addr, f_nidx, f_value};
  assign {h_op, h_addr, h_nidx, h_value} = cq_dout;

  lsfc_cmdq #(
    .WIDTH (Q_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (cq_din),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  lsfc_back #(
    .NUM_INPUTS  (NUM_INPUTS),
    .NUM_NEURONS (NUM_NEURONS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (cq_empty),
    .q_pop          (cq_pop),
    .q_op           (op_t'(h_op)),
    .q_addr         (h_addr),
    .q_nidx         (h_nidx),
    .q_value        ($signed(h_value)),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_spike_mask (out_spike_mask)
  );

endmodule

/* design/lsfc_checker.sv */
// ----------------------------------------------------------------------------
// LIF layer port checker
// Watches the request and result queues of the layer over time.
// ----------------------------------------------------------------------------
`include "lif_spiking_fc_layer_unit_assert.svh"

module lsfc_checker #(
  parameter int NUM_NEURONS = lsfc_pkg::NUM_NEURONS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_spike_mask
);

  `LSFC_ASSERT_RESET(a_reset_empty, out_empty && !in_full, "queues not empty after reset")

  `LSFC_ASSERT_NEXT(a_result_held, !out_empty && !out_pop, !out_empty && $stable(out_spike_mask), "result changed before pop")

  `LSFC_ASSERT_NEXT(a_full_needs_push, !in_full && !in_push, !in_full, "request queue filled without a push")

  `LSFC_ASSERT_IMPL(a_mask_range, !out_empty, (NUM_NEURONS >= 16) || ((out_spike_mask >> NUM_NEURONS) == 16'd0), "mask bit set for a missing neuron")

endmodule

bind lif_spiking_fc_layer_unit lsfc_checker #(
  .NUM_NEURONS (NUM_NEURONS)
) u_lsfc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_spike_mask (out_spike_mask)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF spiking layer testbench
// Loads weights and biases, sends spike, timestep, clear and unused requests
// into the layer under several register settings, and predicts each spike
// mask from a cycle-free model of the accumulators and membranes. Masks are
// checked in order while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lsfc_pkg::*;

  localparam int N_IN          = NUM_INPUTS_DEF;
  localparam int N_NEU         = NUM_NEURONS_DEF;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_ITEMS  = 650;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int CMD_SPACE     = 1 << $bits(cmd_t);
  localparam int CFG_SPACE     = 1 << $bits(cfg_idx_t);
  localparam int CMD_FIRST_UNUSED = int'(CMD_CLEAR) + 1;
  localparam int CFG_FIRST_UNUSED = int'(CFG_INPUT_COUNT) + 1;
  localparam int MAX_COUNT     = 2047;
  localparam int RST_THRESHOLD = 128;
  localparam int RST_DECAY     = 115;
  localparam int RST_SHIFT     = 7;
  localparam logic [30:0] THR_MAX = 31'h7FFFFFFF;
  localparam int INT32_HI      = 32'sh7FFFFFFF;
  localparam int INT32_LO      = 32'sh80000000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [2:0]        in_cmd;
  logic [9:0]        in_pre_index;
  logic [3:0]        in_neuron;
  logic signed [7:0] in_value;
  logic              out_empty;
  logic              out_pop;
  logic [15:0]       out_spike_mask;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [30:0]       cfg_data;

  logic signed [7:0] syn_weight [N_IN][N_NEU];
  logic signed [7:0] nrn_bias [N_NEU];
  logic [N_NEU-1:0]  weight_loaded [N_IN];
  int                acc_sum [N_NEU];
  int                membrane_v [N_NEU];
  int                thr_reg;
  int                decay_reg;
  int                shift_reg;
  int                active_reg;
  int                in_count_reg;

  logic [15:0] expected_masks [$];
  int          full_rows [$];
  int          error_count   = 0;
  int          masks_checked = 0;
  int          requests_sent = 0;
  int          reg_writes    = 0;
  int          cycle_cnt     = 0;
  bit          no_gaps       = 1'b0;
  bit          hold_pop      = 1'b0;

  lif_spiking_fc_layer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_pre_index  (in_pre_index),
    .in_neuron     (in_neuron),
    .in_value      (in_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_spike_mask(out_spike_mask),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d masks outstanding", cycle_cnt,
             expected_masks.size());
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int clamp32(input longint x);
    if (x > longint'(INT32_HI)) return INT32_HI;
    if (x < longint'(INT32_LO)) return INT32_LO;
    return int'(x);
  endfunction

  function automatic logic [9:0] pick_full_row();
    return 10'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void update_layer_state(input logic [2:0] op, input logic [9:0] pre,
                                             input logic [3:0] nrn,
                                             input logic signed [7:0] val);
    int n_act;
    longint v;
    logic [15:0] fired;
    bit was_full;
    n_act = (active_reg < N_NEU) ? active_reg : N_NEU;
    fired = '0;
    case (op)
      CMD_LOAD_W: begin
        was_full = &weight_loaded[pre];
        syn_weight[pre][nrn] = val;
        weight_loaded[pre][nrn] = 1'b1;
        if (!was_full && (&weight_loaded[pre])) full_rows.push_back(int'(pre));
      end
      CMD_LOAD_B: begin
        nrn_bias[nrn] = val;
      end
      CMD_SPIKE: begin
        if (int'(pre) < in_count_reg) begin
          for (int i = 0; i < n_act; i++)
            acc_sum[i] = clamp32(longint'(acc_sum[i]) + longint'(syn_weight[pre][i]));
        end
      end
      CMD_STEP: begin
        for (int i = 0; i < n_act; i++) begin
          v = (longint'(decay_reg) * longint'(membrane_v[i])) >>> shift_reg;
          v = clamp32(v);
          v = clamp32(v + longint'(acc_sum[i]) + longint'(nrn_bias[i]));
          if (v >= longint'(thr_reg)) begin
            v = v - longint'(thr_reg);
            fired[i] = 1'b1;
          end
          membrane_v[i] = int'(v);
        end
        foreach (acc_sum[i]) acc_sum[i] = 0;
        expected_masks.push_back(fired);
      end
      CMD_CLEAR: begin
        foreach (acc_sum[i]) acc_sum[i] = 0;
        foreach (membrane_v[i]) membrane_v[i] = 0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic push_req(input logic [2:0] op, input logic [9:0] pre,
                          input logic [3:0] nrn, input logic signed [7:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_cmd       <= op;
    in_pre_index <= pre;
    in_neuron    <= nrn;
    in_value     <= val;
    do @(posedge clk); while (in_full);
    requests_sent++;
    update_layer_state(op, pre, nrn, val);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_THRESHOLD:   thr_reg      = int'(data);
      CFG_DECAY:       decay_reg    = int'(data[6:0]);
      CFG_SHIFT:       shift_reg    = int'(data[4:0]);
      CFG_ACTIVE:      active_reg   = int'(data[4:0]);
      CFG_INPUT_COUNT: in_count_reg = int'(data[10:0]);
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [30:0] thr, input int dec, input int sh,
                          input int act, input int cnt);
    drain_results();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_DECAY, {24'($urandom), 7'(dec)});
    write_reg(CFG_SHIFT, {26'($urandom), 5'(sh)});
    write_reg(CFG_ACTIVE, {26'($urandom), 5'(act)});
    write_reg(CFG_INPUT_COUNT, {20'($urandom), 11'(cnt)});
  endtask

  task automatic load_row(input int pre);
    for (int n = 0; n < N_NEU; n++)
      push_req(CMD_LOAD_W, 10'(pre), 4'(n), 8'($urandom));
  endtask

  task automatic run_timestep(input int n_spikes);
    for (int k = 0; k < n_spikes; k++)
      push_req(CMD_SPIKE, pick_full_row(), 4'($urandom), 8'($urandom));
    push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic prime_stores();
    push_req(CMD_LOAD_B, 10'($urandom), 4'd0, -8'sd128);
    push_req(CMD_LOAD_B, 10'($urandom), 4'd1, 8'sd127);
    for (int n = 2; n < N_NEU; n++)
      push_req(CMD_LOAD_B, 10'($urandom), 4'(n), 8'($urandom));
    load_row(0);
    load_row(N_IN - 1);
    repeat (6) load_row($urandom_range(1, N_IN - 2));
  endtask

  task automatic test_timestep_basics();
    push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
    push_req(CMD_LOAD_W, 10'd0, 4'd0, -8'sd128);
    push_req(CMD_LOAD_W, 10'(N_IN - 1), 4'(N_NEU - 1), 8'sd127);
    push_req(CMD_SPIKE, 10'd0, 4'($urandom), 8'($urandom));
    push_req(CMD_SPIKE, 10'(N_IN - 1), 4'($urandom), 8'($urandom));
    push_req(CMD_SPIKE, 10'd0, 4'($urandom), 8'($urandom));
    push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
    for (int op = CMD_FIRST_UNUSED; op < CMD_SPACE; op++)
      push_req(3'(op), 10'($urandom), 4'($urandom), 8'($urandom));
    push_req(CMD_SPIKE, 10'(N_IN - 1), 4'($urandom), 8'($urandom));
    push_req(CMD_CLEAR, 10'($urandom), 4'($urandom), 8'($urandom));
    push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
    run_timestep(1);
  endtask

  task automatic test_register_extremes();
    set_regs(31'd0, RST_DECAY, RST_SHIFT, 31, N_IN);
    run_timestep(3);
    run_timestep(0);
    set_regs(31'd1, 0, 31, 0, N_IN);
    run_timestep(2);
    set_regs(31'd50, 127, 31, 1, 1);
    push_req(CMD_SPIKE, 10'd0, 4'($urandom), 8'($urandom));
    push_req(CMD_SPIKE, 10'(N_IN - 1), 4'($urandom), 8'($urandom));
    push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
    set_regs(31'd50, 64, 1, N_NEU, 0);
    run_timestep(2);
    set_regs(THR_MAX, 0, 0, N_NEU, MAX_COUNT);
    for (int k = CFG_FIRST_UNUSED; k < CFG_SPACE; k++)
      write_reg(3'(k), 31'($urandom));
    push_req(CMD_SPIKE, 10'(N_IN - 1), 4'($urandom), 8'($urandom));
    push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic test_membrane_saturation();
    set_regs(THR_MAX, 127, 0, N_NEU, N_IN);
    push_req(CMD_CLEAR, 10'($urandom), 4'($urandom), 8'($urandom));
    repeat (8) run_timestep(2);
    set_regs(31'd1000, 127, 0, N_NEU, N_IN);
    repeat (3) run_timestep(1);
    set_regs(31'(RST_THRESHOLD), RST_DECAY, RST_SHIFT, N_NEU, N_IN);
  endtask

  task automatic test_backpressure();
    drain_results();
    no_gaps  = 1'b1;
    hold_pop = 1'b1;
    repeat (8) run_timestep(2);
    no_gaps  = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start_cnt;
    int seq_n;
    logic [30:0] thr;
    int sh;
    int act;
    int cnt;
    start_cnt = requests_sent;
    seq_n = 0;
    while (requests_sent - start_cnt < RANDOM_ITEMS) begin
      if (seq_n % 8 == 7) begin
        case ($urandom_range(0, 7))
          0: thr = 31'($urandom);
          1: thr = 31'd0;
          default: thr = 31'($urandom_range(1, 600));
        endcase
        sh  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
        act = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, N_NEU);
        cnt = ($urandom_range(0, 1) == 0) ? N_IN : $urandom_range(0, MAX_COUNT);
        set_regs(thr, $urandom_range(0, 127), sh, act, cnt);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      seq_n++;
      if ($urandom_range(0, 9) == 0) load_row($urandom_range(0, N_IN - 1));
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 19))
          0: begin
            if (in_count_reg < N_IN)
              push_req(CMD_SPIKE, 10'($urandom_range(in_count_reg, N_IN - 1)),
                       4'($urandom), 8'($urandom));
            else
              push_req(CMD_SPIKE, pick_full_row(), 4'($urandom), 8'($urandom));
          end
          1: push_req(3'($urandom_range(CMD_FIRST_UNUSED, CMD_SPACE - 1)), 10'($urandom),
                      4'($urandom), 8'($urandom));
          2: push_req(CMD_LOAD_W, 10'($urandom), 4'($urandom), 8'($urandom));
          3: push_req(CMD_LOAD_B, 10'($urandom), 4'($urandom), 8'($urandom));
          4: begin
            if ($urandom_range(0, 3) == 0)
              push_req(CMD_CLEAR, 10'($urandom), 4'($urandom), 8'($urandom));
            else
              push_req(CMD_SPIKE, pick_full_row(), 4'($urandom), 8'($urandom));
          end
          default: push_req(CMD_SPIKE, pick_full_row(), 4'($urandom), 8'($urandom));
        endcase
      end
      push_req(CMD_STEP, 10'($urandom), 4'($urandom), 8'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  initial begin : mask_sink
    int wait_n;
    logic [15:0] want;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pop) begin
        wait_n = HOLD_CYCLES;
        hold_pop = 1'b0;
      end else begin
        wait_n = draw_gap();
      end
      if (wait_n > 0) begin
        out_pop <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (expected_masks.size() == 0) begin
        report_mismatch($sformatf("spike mask %h arrived with none pending", out_spike_mask));
      end else begin
        want = expected_masks.pop_front();
        masks_checked++;
        if (out_spike_mask !== want)
          report_mismatch($sformatf("spike mask %h, expected %h", out_spike_mask, want));
      end
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_push      <= 1'b0;
    in_cmd       <= CMD_LOAD_W;
    in_pre_index <= '0;
    in_neuron    <= '0;
    in_value     <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_THRESHOLD;
    cfg_data     <= '0;
    thr_reg      = RST_THRESHOLD;
    decay_reg    = RST_DECAY;
    shift_reg    = RST_SHIFT;
    active_reg   = N_NEU;
    in_count_reg = N_IN;
    foreach (weight_loaded[r]) weight_loaded[r] = '0;
    foreach (acc_sum[i]) acc_sum[i] = 0;
    foreach (membrane_v[i]) membrane_v[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prime_stores();
    test_timestep_basics();
    test_register_extremes();
    test_membrane_saturation();
    test_backpressure();
    test_random_traffic();
    drain_results();

    $display("Sent %0d requests and %0d register writes over %0d weight rows.",
             requests_sent, reg_writes, full_rows.size());
    $display("Checked %0d spike masks, %0d mismatches.", masks_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/lsfc_pkg.sv
design/lsfc_cmdq.sv
design/lsfc_front.sv
design/lsfc_back.sv
design/lif_spiking_fc_layer_unit.sv
design/lsfc_checker.sv
verif/tb_top.sv
